// ===== rtl/p2fill_pkg.sv =====
// shared types, constants and pixel functions for the 2bpp rectangle fill block
// no dependencies
package p2fill_pkg;

	localparam int SCREEN_WIDTH  = 160;
	localparam int SCREEN_HEIGHT = 128;
	localparam int ROW_BYTES     = (SCREEN_WIDTH + 3) / 4;
	localparam int FRAME_BYTES   = ROW_BYTES * SCREEN_HEIGHT;

	localparam int ADDR_W  = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
	localparam int COL_W   = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
	localparam int ROW_W   = $clog2(SCREEN_HEIGHT + 1);
	localparam int DIM_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ?
		((SCREEN_WIDTH > 256) ? SCREEN_WIDTH : 256) :
		((SCREEN_HEIGHT > 256) ? SCREEN_HEIGHT : 256);
	localparam int CW      = $clog2(DIM_MAX + 1);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_DRAW_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FG_LEVEL  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BG_LEVEL  = 2'd2;

	localparam logic [1:0] ITEM_FILL  = 2'd0;
	localparam logic [1:0] ITEM_WRITE = 2'd1;
	localparam logic [1:0] ITEM_READ  = 2'd2;

	localparam logic [2:0] DM_COMPLEMENT   = 3'd0;
	localparam logic [2:0] DM_BG           = 3'd1;
	localparam logic [2:0] DM_FG           = 3'd2;
	localparam logic [2:0] DM_SOLID        = 3'd3;
	localparam logic [2:0] DM_INV_COMP     = 3'd4;
	localparam logic [2:0] DM_INV_BG       = 3'd5;
	localparam logic [2:0] DM_INV_FG       = 3'd6;
	localparam logic [2:0] DM_INV_SOLID    = 3'd7;

	localparam logic [2:0] DRAW_MODE_RESET = DM_SOLID;
	localparam logic [1:0] FG_LEVEL_RESET  = 2'd0;
	localparam logic [1:0] BG_LEVEL_RESET  = 2'd3;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] pixel_x;
		logic [6:0] pixel_y;
		logic [7:0] rect_width;
		logic [7:0] rect_height;
		logic [7:0] write_byte;
	} cmd_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       nothing_drawn;
	} res_t;

	// stored pixel is 3 minus level, replicated over four pixels
	function automatic logic [7:0] level_pattern(input logic [1:0] level);
		level_pattern = {4{~level}};
	endfunction

	function automatic logic [7:0] apply_mode(
		input logic [2:0] draw_mode,
		input logic [1:0] fg_level,
		input logic [1:0] bg_level,
		input logic [7:0] data,
		input logic [7:0] mask
	);
		logic [7:0] fg;
		logic [7:0] bg;
		fg = level_pattern(fg_level);
		bg = level_pattern(bg_level);
		case (draw_mode)
			DM_COMPLEMENT: apply_mode = data ^ mask;
			DM_FG, DM_SOLID: apply_mode = data ^ ((data ^ fg) & mask);
			DM_INV_BG, DM_INV_SOLID: apply_mode = data ^ ((data ^ bg) & mask);
			default: apply_mode = data;
		endcase
	endfunction

endpackage

// ===== rtl/p2fill_ram.sv =====
// generic single-clock ram, one write port and one registered read port
// no dependencies
module p2fill_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/packed_2bpp_rect_fill_rop.sv =====
// 2bpp packed framebuffer with clipped rectangle fill under raster-op draw modes
// depends on p2fill_pkg and p2fill_ram
// write and unused items end in the decode state; read items pass decode and a read-data state
// fill: decode, prep and mask states, then a read and a modify-write state per covered byte on the
// single frame ram, then the result; an empty rectangle answers from the decode state
// busy stays high from the transfer until the result cycle; the next item may start then
// after reset a clearing pass zeroes all 5120 frame bytes with busy high
module packed_2bpp_rect_fill_rop (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  p2fill_pkg::cmd_t                      cmd,
	output logic                                  busy,
	output logic                                  done,
	output p2fill_pkg::res_t                      result,
	input  logic                                  cfg_we,
	input  logic [p2fill_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [p2fill_pkg::CFG_DATA_W-1:0]     cfg_data
);

	typedef enum logic [7:0] {
		ST_CLEAR   = 8'b0000_0001,
		ST_IDLE    = 8'b0000_0010,
		ST_DECODE  = 8'b0000_0100,
		ST_PREP    = 8'b0000_1000,
		ST_MASK    = 8'b0001_0000,
		ST_RD      = 8'b0010_0000,
		ST_WR      = 8'b0100_0000,
		ST_RD_DATA = 8'b1000_0000
	} state_t;

	localparam int AW    = p2fill_pkg::ADDR_W;
	localparam int CW    = p2fill_pkg::CW;
	localparam int COL_W = p2fill_pkg::COL_W;
	localparam int ROW_W = p2fill_pkg::ROW_W;

	state_t                   state_q;
	p2fill_pkg::cmd_t         cmd_q;
	p2fill_pkg::res_t         res_q;
	logic                     done_q;
	logic [2:0]               draw_mode_q;
	logic [1:0]               fg_level_q;
	logic [1:0]               bg_level_q;
	logic [AW-1:0]            addr_q;
	logic [AW-1:0]            row_base_q;
	logic [COL_W-1:0]         col_q;
	logic [COL_W-1:0]         first_col_q;
	logic [COL_W-1:0]         last_col_q;
	logic [7:0]               lmask_q;
	logic [7:0]               rmask_q;
	logic [CW-1:0]            wc_q;
	logic [ROW_W-1:0]         hc_q;
	logic [ROW_W-1:0]         rows_left_q;

	logic [CW-1:0]            x_e;
	logic [CW-1:0]            y_e;
	logic [CW-1:0]            avail_w;
	logic [CW-1:0]            avail_h;
	logic [CW-1:0]            wc;
	logic [CW-1:0]            hc;
	logic                     empty;
	logic                     in_frame;
	logic [AW-1:0]            byte_addr;
	logic [CW-1:0]            last_px;
	logic [AW-1:0]            row_next;
	logic [7:0]               mask;
	logic                     last_col;
	logic                     last_clear;
	logic                     item_end;

	logic                     ram_we;
	logic [AW-1:0]            ram_waddr;
	logic [7:0]               ram_wdata;
	logic [AW-1:0]            ram_raddr;
	logic [7:0]               ram_rdata;

	p2fill_ram #(
		.WIDTH (8),
		.DEPTH (p2fill_pkg::FRAME_BYTES)
	) u_frame (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// clip and address of the held item
	always_comb begin
		x_e       = CW'(cmd_q.pixel_x);
		y_e       = CW'(cmd_q.pixel_y);
		avail_w   = CW'(p2fill_pkg::SCREEN_WIDTH) - x_e;
		avail_h   = CW'(p2fill_pkg::SCREEN_HEIGHT) - y_e;
		wc        = (CW'(cmd_q.rect_width) > avail_w) ? avail_w : CW'(cmd_q.rect_width);
		hc        = (CW'(cmd_q.rect_height) > avail_h) ? avail_h : CW'(cmd_q.rect_height);
		empty     = (x_e >= CW'(p2fill_pkg::SCREEN_WIDTH)) ||
		            (y_e >= CW'(p2fill_pkg::SCREEN_HEIGHT)) ||
		            (cmd_q.rect_width == 8'd0) || (cmd_q.rect_height == 8'd0);
		in_frame  = (CW'(cmd_q.pixel_x[7:2]) < CW'(p2fill_pkg::ROW_BYTES)) &&
		            (y_e < CW'(p2fill_pkg::SCREEN_HEIGHT));
		byte_addr = AW'(AW'(cmd_q.pixel_y) * AW'(p2fill_pkg::ROW_BYTES)) +
		            AW'(cmd_q.pixel_x[7:2]);
		last_px   = x_e + wc_q - CW'(1);
		row_next  = row_base_q + AW'(p2fill_pkg::ROW_BYTES);
		last_col  = (col_q == last_col_q);
		mask      = 8'hFF;
		if (col_q == first_col_q) begin
			mask = mask & lmask_q;
		end
		if (last_col) begin
			mask = mask & rmask_q;
		end
		last_clear = (addr_q == AW'(p2fill_pkg::FRAME_BYTES - 1));
		// the item finishes at this edge, result shown in the next cycle
		case (state_q)
			ST_DECODE: begin
				item_end = (cmd_q.mode != p2fill_pkg::ITEM_READ) &&
				           !((cmd_q.mode == p2fill_pkg::ITEM_FILL) && !empty);
			end
			ST_RD_DATA: begin
				item_end = 1'b1;
			end
			ST_WR: begin
				item_end = last_col && (rows_left_q == ROW_W'(1));
			end
			default: begin
				item_end = 1'b0;
			end
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = 8'h00;
		ram_raddr = addr_q;
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_DECODE: begin
				ram_raddr = byte_addr;
				ram_waddr = byte_addr;
				ram_wdata = cmd_q.write_byte;
				ram_we    = (cmd_q.mode == p2fill_pkg::ITEM_WRITE) && in_frame;
			end
			ST_WR: begin
				ram_we    = 1'b1;
				ram_wdata = p2fill_pkg::apply_mode(draw_mode_q, fg_level_q, bg_level_q,
				                                   ram_rdata, mask);
			end
			default: begin
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draw_mode_q <= p2fill_pkg::DRAW_MODE_RESET;
			fg_level_q  <= p2fill_pkg::FG_LEVEL_RESET;
			bg_level_q  <= p2fill_pkg::BG_LEVEL_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				p2fill_pkg::CFG_DRAW_MODE: draw_mode_q <= cfg_data;
				p2fill_pkg::CFG_FG_LEVEL:  fg_level_q  <= cfg_data[1:0];
				p2fill_pkg::CFG_BG_LEVEL:  bg_level_q  <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cmd_q       <= '0;
			res_q       <= '0;
			addr_q      <= '0;
			done_q      <= 1'b0;
			rows_left_q <= '0;
			col_q       <= '0;
			row_base_q  <= '0;
			first_col_q <= '0;
			last_col_q  <= '0;
			lmask_q     <= '0;
			rmask_q     <= '0;
			wc_q        <= '0;
			hc_q        <= '0;
		end else begin
			done_q <= item_end;
			case (state_q)
				ST_CLEAR: begin
					addr_q <= addr_q + AW'(1);
					if (last_clear) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						cmd_q   <= cmd;
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					res_q <= '{read_byte: 8'h00,
					           nothing_drawn: (cmd_q.mode == p2fill_pkg::ITEM_FILL) && empty};
					wc_q  <= wc;
					hc_q  <= ROW_W'(hc);
					case (cmd_q.mode)
						p2fill_pkg::ITEM_FILL: begin
							if (empty) begin
								state_q <= ST_IDLE;
							end else begin
								state_q <= ST_PREP;
							end
						end
						p2fill_pkg::ITEM_READ: begin
							state_q <= ST_RD_DATA;
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_RD_DATA: begin
					res_q.read_byte <= in_frame ? ram_rdata : 8'h00;
					state_q         <= ST_IDLE;
				end
				ST_PREP: begin
					row_base_q  <= AW'(AW'(cmd_q.pixel_y) * AW'(p2fill_pkg::ROW_BYTES));
					rows_left_q <= hc_q;
					first_col_q <= COL_W'(cmd_q.pixel_x[7:2]);
					last_col_q  <= COL_W'(last_px >> 2);
					lmask_q     <= 8'hFF >> {cmd_q.pixel_x[1:0], 1'b0};
					rmask_q     <= 8'hFF << {~last_px[1:0], 1'b0};
					state_q     <= ST_MASK;
				end
				ST_MASK: begin
					addr_q  <= row_base_q + AW'(first_col_q);
					col_q   <= first_col_q;
					state_q <= ST_RD;
				end
				ST_RD: begin
					state_q <= ST_WR;
				end
				ST_WR: begin
					if (last_col) begin
						if (rows_left_q == ROW_W'(1)) begin
							state_q <= ST_IDLE;
						end else begin
							state_q     <= ST_RD;
							rows_left_q <= rows_left_q - ROW_W'(1);
							row_base_q  <= row_next;
							addr_q      <= row_next + AW'(first_col_q);
							col_q       <= first_col_q;
						end
					end else begin
						state_q <= ST_RD;
						addr_q  <= addr_q + AW'(1);
						col_q   <= col_q + COL_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

endmodule

// ===== rtl/p2fill_chk.sv =====
// port-level checks for packed_2bpp_rect_fill_rop, attached by bind
// depends on p2fill_pkg
module p2fill_chk (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input p2fill_pkg::res_t result
);

	// the result strobe comes only as the block goes idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a preceding busy period");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("transfer not followed by busy");

	a_single_field: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.nothing_drawn && (result.read_byte != 8'h00)))
		else $error("read data and empty flag together");

endmodule

bind packed_2bpp_rect_fill_rop p2fill_chk u_p2fill_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
